/* rtl/dtv_pkg.sv */
// ---------------------------------------------------------------------------
// dtv_pkg: date text validator shared definitions
// Character codes, field and status encodings, the month length table and
// the small arithmetic helpers of the validator.
// ---------------------------------------------------------------------------
package dtv_pkg;

	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_NINE  = 8'd57;
	localparam logic [7:0] CHAR_SPACE = 8'd32;
	localparam logic [7:0] CHAR_DOT   = 8'd46;

	localparam logic [7:0]  SMALL_CAP = 8'd255;
	localparam logic [16:0] YEAR_CAP  = 17'd65536;

	localparam logic [4:0] FEB_LEAP = 5'd29;
	localparam logic [4:0] FEB_NORM = 5'd28;

	typedef enum logic [1:0] {
		FIELD_DAY   = 2'd0,
		FIELD_MONTH = 2'd1,
		FIELD_YEAR  = 2'd2
	} field_t;

	typedef enum logic [1:0] {
		STATUS_VALID  = 2'd0,
		STATUS_FORMAT = 2'd1,
		STATUS_DATE   = 2'd2
	} status_t;

	// days in month; february gives its non-leap length
	function automatic logic [4:0] month_days(input logic [3:0] m);
		logic [4:0] d;
		unique case (m)
			4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
			4'd2:                    d = FEB_NORM;
			default:                 d = 5'd31;
		endcase
		return d;
	endfunction

	// remainder by 25 of a value below 256, via reciprocal 41/1024
	function automatic logic [4:0] mod25(input logic [7:0] v);
		logic [13:0] p;
		logic [3:0]  q;
		logic [7:0]  r;
		p = {6'd0, v} * 14'd41;
		q = p[13:10];
		r = v - ({4'd0, q} * 8'd25);
		return r[4:0];
	endfunction

endpackage

/* rtl/dtv_char_if.sv */
// ---------------------------------------------------------------------------
// dtv_char_if: character channel
// Valid/ready channel carrying one text byte and its last-character mark.
// ---------------------------------------------------------------------------
interface dtv_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

/* rtl/dtv_result_if.sv */
// ---------------------------------------------------------------------------
// dtv_result_if: result channel
// Valid/ready channel carrying the status and the parsed day, month, year.
// ---------------------------------------------------------------------------
interface dtv_result_if;
	logic              valid;
	logic              ready;
	dtv_pkg::status_t  status;
	logic [7:0]        day_value;
	logic [7:0]        month_value;
	logic [15:0]       year_value;

	modport source (output valid, output status, output day_value, output month_value,
		output year_value, input ready);
	modport sink   (input valid, input status, input day_value, input month_value,
		input year_value, output ready);
endinterface

/* rtl/date_text_validator_top.sv */
// ---------------------------------------------------------------------------
// date_text_validator_top: day.month.year text checker
// Takes a date text one byte per transaction on the chars channel, with
// last_char set on the final byte. Digits build the day, month and year;
// a dot moves to the next field; a single space inside a field is ignored.
// On the final byte one transaction leaves on the results channel with the
// status (valid, wrong format, wrong date) and the three numbers, which
// read zero on a format error. Bytes that are not final give no result.
// Throughput is one byte per cycle unless a final byte waits for a stalled
// result. A byte enters the input register and from there updates the parse
// state; a final byte also loads the result register, which offers the result.
// When results stalls, the result register holds; the input register keeps
// taking bytes that are not final, and a final byte waits in the input
// register until the result register is free, which drops chars.ready.
// Reset (arst_n low) empties both registers and clears the parse state;
// each final byte also returns the parse state to its reset value.
// ---------------------------------------------------------------------------
module date_text_validator_top (
	input  logic         clk,
	input  logic         arst_n,
	dtv_char_if.sink     chars,
	dtv_result_if.source results
);
	import dtv_pkg::*;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;
	logic       fire_s1;

	field_t      field_q, field_d;
	logic        space_q, space_d;
	logic        dot_q, dot_d;
	logic        bad_q, bad_d;
	logic [7:0]  day_q, day_d;
	logic [7:0]  month_q, month_d;
	logic [16:0] year_q, year_d;
	logic [4:0]  ymod_q, ymod_d;
	logic [2:0]  digits_q, digits_d;

	logic        out_valid_q;
	status_t     status_q, status_d;
	logic [7:0]  day_out_q, day_out_d;
	logic [7:0]  month_out_q, month_out_d;
	logic [15:0] year_out_q, year_out_d;

	logic        is_digit;
	logic [3:0]  dval;
	logic [11:0] day_prod;
	logic [11:0] month_prod;
	logic [20:0] year_prod;
	logic [7:0]  ymod_prod;
	logic        fmt_bad;
	logic        leap;
	logic [4:0]  limit;
	logic        date_ok;

	assign fire_s1      = valid_s1 && (!last_s1 || !out_valid_q || results.ready);
	assign chars.ready  = !valid_s1 || fire_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			char_s1 <= chars.char_code;
			last_s1 <= chars.last_char;
		end
	end

	// parse step
	assign is_digit   = (char_s1 >= CHAR_ZERO) && (char_s1 <= CHAR_NINE);
	assign dval       = char_s1[3:0];
	assign day_prod   = {4'd0, day_q} * 12'd10 + {8'd0, dval};
	assign month_prod = {4'd0, month_q} * 12'd10 + {8'd0, dval};
	assign year_prod  = {4'd0, year_q} * 21'd10 + {17'd0, dval};
	assign ymod_prod  = {3'd0, ymod_q} * 8'd10 + {4'd0, dval};

	always_comb begin
		field_d  = field_q;
		space_d  = space_q;
		dot_d    = dot_q;
		bad_d    = bad_q;
		day_d    = day_q;
		month_d  = month_q;
		year_d   = year_q;
		ymod_d   = ymod_q;
		digits_d = digits_q;
		if (!bad_q) begin
			if (is_digit) begin
				unique case (field_q)
					FIELD_DAY:   day_d   = (day_prod > {4'd0, SMALL_CAP}) ? SMALL_CAP
						: day_prod[7:0];
					FIELD_MONTH: month_d = (month_prod > {4'd0, SMALL_CAP}) ? SMALL_CAP
						: month_prod[7:0];
					default: begin
						year_d = (year_prod > {4'd0, YEAR_CAP}) ? YEAR_CAP
							: year_prod[16:0];
						ymod_d = mod25(ymod_prod);
					end
				endcase
				digits_d = digits_q | (3'b001 << field_q);
				dot_d    = 1'b0;
			end else if (char_s1 == CHAR_SPACE) begin
				if (space_q) begin
					bad_d = 1'b1;
				end
				space_d = 1'b1;
			end else if (char_s1 == CHAR_DOT) begin
				if (field_q == FIELD_YEAR || dot_q) begin
					bad_d = 1'b1;
				end else begin
					dot_d   = 1'b1;
					field_d = field_t'(field_q + 2'd1);
					space_d = 1'b0;
				end
			end else begin
				bad_d = 1'b1;
			end
		end
	end

	// date check on the updated fields
	always_comb begin
		fmt_bad = bad_d || (digits_d != 3'b111);
		leap    = (year_d[1:0] == 2'd0) && ((ymod_d != 5'd0) || (year_d[3:0] == 4'd0));
		limit   = (month_d == 8'd2) ? (leap ? FEB_LEAP : FEB_NORM) : month_days(month_d[3:0]);
		date_ok = !year_d[16] && (month_d >= 8'd1) && (month_d <= 8'd12)
			&& (day_d <= {3'd0, limit});
		if (fmt_bad) begin
			status_d    = STATUS_FORMAT;
			day_out_d   = 8'd0;
			month_out_d = 8'd0;
			year_out_d  = 16'd0;
		end else begin
			status_d    = date_ok ? STATUS_VALID : STATUS_DATE;
			day_out_d   = day_d;
			month_out_d = month_d;
			year_out_d  = year_d[16] ? 16'hFFFF : year_d[15:0];
		end
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_q  <= FIELD_DAY;
			space_q  <= 1'b0;
			dot_q    <= 1'b0;
			bad_q    <= 1'b0;
			day_q    <= 8'd0;
			month_q  <= 8'd0;
			year_q   <= 17'd0;
			ymod_q   <= 5'd0;
			digits_q <= 3'd0;
		end else if (fire_s1) begin
			if (last_s1) begin
				field_q  <= FIELD_DAY;
				space_q  <= 1'b0;
				dot_q    <= 1'b0;
				bad_q    <= 1'b0;
				day_q    <= 8'd0;
				month_q  <= 8'd0;
				year_q   <= 17'd0;
				ymod_q   <= 5'd0;
				digits_q <= 3'd0;
			end else begin
				field_q  <= field_d;
				space_q  <= space_d;
				dot_q    <= dot_d;
				bad_q    <= bad_d;
				day_q    <= day_d;
				month_q  <= month_d;
				year_q   <= year_d;
				ymod_q   <= ymod_d;
				digits_q <= digits_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1) begin
			status_q    <= status_d;
			day_out_q   <= day_out_d;
			month_out_q <= month_out_d;
			year_out_q  <= year_out_d;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.status      = status_q;
	assign results.day_value   = day_out_q;
	assign results.month_value = month_out_q;
	assign results.year_value  = year_out_q;

endmodule

/* rtl/dtv_checker.sv */
// ---------------------------------------------------------------------------
// dtv_checker: port checks for the date text validator
// Watches the result channel of the top level; bound to it below.
// ---------------------------------------------------------------------------
module dtv_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             res_valid,
	input logic             res_ready,
	input dtv_pkg::status_t res_status,
	input logic [7:0]       res_day,
	input logic [7:0]       res_month,
	input logic [15:0]      res_year
);
	import dtv_pkg::*;

	// stalled transaction holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_status)
		&& $stable(res_day) && $stable(res_month) && $stable(res_year))
		else $error("result changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_status == STATUS_VALID) || (res_status == STATUS_FORMAT)
		|| (res_status == STATUS_DATE))
		else $error("undefined status");

	a_format_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_status == STATUS_FORMAT)
		|-> (res_day == 8'd0) && (res_month == 8'd0) && (res_year == 16'd0))
		else $error("format error with nonzero fields");

	a_valid_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_status == STATUS_VALID)
		|-> (res_month >= 8'd1) && (res_month <= 8'd12) && (res_day <= 8'd31))
		else $error("valid status with out of range date");

endmodule

bind date_text_validator_top dtv_checker u_dtv_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (results.valid),
	.res_ready  (results.ready),
	.res_status (results.status),
	.res_day    (results.day_value),
	.res_month  (results.month_value),
	.res_year   (results.year_value)
);
